### design/ckd_pkg.sv
// Shared types and constants for the chord key debouncer.
// Used by ckd_lane, ckd_merge and chord_key_debouncer_core; no dependencies.
package ckd_pkg;

  localparam int KEY_COUNT_DEF = 40;
  localparam int FIELD_W       = 40;
  localparam int TIME_W        = 16;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;

  localparam logic [TIME_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [TIME_W-1:0] CHORD_RST    = 16'd500;

  typedef enum logic {
    REG_DEBOUNCE = 1'b0,
    REG_CHORD    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0]  now_time;
    logic [FIELD_W-1:0] raw_keys;
  } in_beat_t;

  typedef struct packed {
    logic [FIELD_W-1:0] pressed_keys;
    logic               chord_seen;
    logic               hold_active;
    logic [FIELD_W-1:0] chord_keys;
  } out_beat_t;

endpackage

### design/chord_key_debouncer_core.sv
// Chord key debouncer: takes one key scan per beat (16-bit timer value plus
// 40 raw key bits) and returns one result beat with the debounced pressed
// mask, chord and hold flags and the latched chord mask. Every key has its
// own lane that keeps the time of its last release; all lanes compare in
// parallel and a merge stage updates the masks, so a new scan can be taken
// every cycle while the output is not stalled. The result sits in the state
// registers and out_valid stays high until the beat is taken; a stalled
// output blocks input. Raw bits at or above KEY_COUNT are ignored.
// Depends on ckd_pkg, ckd_lane, ckd_merge.
module chord_key_debouncer_core #(
  parameter int KEY_COUNT = ckd_pkg::KEY_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // scan input
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ckd_pkg::in_beat_t           in_data,
  // result output
  output logic                        out_valid,
  input  logic                        out_ready,
  output ckd_pkg::out_beat_t          out_data,
  // APB-style register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ckd_pkg::ADDR_W-1:0]  paddr,
  input  logic [ckd_pkg::DATA_W-1:0]  pwdata,
  output logic [ckd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int CW = (KEY_COUNT > ckd_pkg::FIELD_W) ? KEY_COUNT : ckd_pkg::FIELD_W;

  logic [ckd_pkg::TIME_W-1:0] debounce_r;
  logic [ckd_pkg::TIME_W-1:0] chord_time_r;
  logic                       out_valid_r;
  logic                       in_fire;
  logic                       cfg_wr;
  ckd_pkg::reg_idx_t          reg_sel;
  logic [CW-1:0]              raw_wide;
  logic [KEY_COUNT-1:0]       keys;
  logic                       all_released;
  logic [KEY_COUNT-1:0]       press_hits;
  logic [KEY_COUNT-1:0]       chord_hits;

  // ---- register port ----
  assign pready  = 1'b1;
  assign reg_sel = ckd_pkg::reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= ckd_pkg::DEBOUNCE_RST;
      chord_time_r <= ckd_pkg::CHORD_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        ckd_pkg::REG_DEBOUNCE: debounce_r   <= pwdata[ckd_pkg::TIME_W-1:0];
        ckd_pkg::REG_CHORD:    chord_time_r <= pwdata[ckd_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ckd_pkg::REG_DEBOUNCE: prdata = ckd_pkg::DATA_W'(debounce_r);
      ckd_pkg::REG_CHORD:    prdata = ckd_pkg::DATA_W'(chord_time_r);
      default:               prdata = '0;
    endcase
  end

  // ---- handshake: result held in merge state until taken ----
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

  // keys beyond the 40-bit field read as released
  assign raw_wide     = CW'(in_data.raw_keys);
  assign keys         = raw_wide[KEY_COUNT-1:0];
  assign all_released = (keys == '0);

  // ---- per-key lanes ----
  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lane
    ckd_lane u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .step         (in_fire),
      .key_down     (keys[k]),
      .now_time     (in_data.now_time),
      .debounce_time(debounce_r),
      .chord_time   (chord_time_r),
      .press_hit    (press_hits[k]),
      .chord_hit    (chord_hits[k])
    );
  end

  // ---- merge of lane results ----
  ckd_merge #(
    .KEY_COUNT(KEY_COUNT)
  ) u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_fire),
    .all_released(all_released),
    .press_hits  (press_hits),
    .chord_hits  (chord_hits),
    .result      (out_data)
  );

`ifndef NO_ASSERTIONS
  // hold is only ever set together with or after the chord flag
  a_hold_needs_chord: assert property (@(posedge clk) disable iff (!rst_n)
    out_data.hold_active |-> out_data.chord_seen)
    else $error("hold active without chord flag");

  // latching a chord copies the current pressed mask
  a_latch_copies_mask: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_data.hold_active) |-> (out_data.chord_keys == out_data.pressed_keys))
    else $error("latched chord differs from pressed mask");

  // an all-released scan with nonzero debounce leaves nothing pressed
  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && all_released && (debounce_r != '0)) |=> (out_data.pressed_keys == '0))
    else $error("pressed mask not cleared on full release");

  // every accepted scan yields a result beat
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid)
    else $error("accepted scan produced no result");
`endif

endmodule

### design/ckd_lane.sv
// One key lane: release stamp register and the two threshold compares.
// Depends on ckd_pkg.
module ckd_lane (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic                      key_down,
  input  logic [ckd_pkg::TIME_W-1:0] now_time,
  input  logic [ckd_pkg::TIME_W-1:0] debounce_time,
  input  logic [ckd_pkg::TIME_W-1:0] chord_time,
  output logic                      press_hit,
  output logic                      chord_hit
);

  logic [ckd_pkg::TIME_W-1:0] stamp_r;
  logic [ckd_pkg::TIME_W-1:0] stamp_nxt;
  logic [ckd_pkg::TIME_W-1:0] elapsed;

  // a released key restamps to now, so its elapsed time is zero this beat
  assign stamp_nxt = key_down ? stamp_r : now_time;
  assign elapsed   = now_time - stamp_nxt;   // wraps modulo 2^16
  assign press_hit = (elapsed >= debounce_time);
  assign chord_hit = (elapsed >= chord_time);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_r <= '0;
    end else if (step) begin
      stamp_r <= stamp_nxt;
    end
  end

endmodule

### design/ckd_merge.sv
// Merge stage: folds lane hits into pressed mask, chord/hold flags and latch.
// Depends on ckd_pkg.
module ckd_merge #(
  parameter int KEY_COUNT = ckd_pkg::KEY_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic                   all_released,
  input  logic [KEY_COUNT-1:0]   press_hits,
  input  logic [KEY_COUNT-1:0]   chord_hits,
  output ckd_pkg::out_beat_t     result
);

  localparam int CW = (KEY_COUNT > ckd_pkg::FIELD_W) ? KEY_COUNT : ckd_pkg::FIELD_W;

  logic [KEY_COUNT-1:0] pressed_r, pressed_nxt;
  logic [KEY_COUNT-1:0] latched_r, latched_nxt;
  logic                 chord_r, chord_nxt;
  logic                 hold_r, hold_nxt;
  logic                 hold_base;
  logic [CW-1:0]        pressed_wide;
  logic [CW-1:0]        latched_wide;

  always_comb begin
    pressed_nxt = (all_released ? '0 : pressed_r) | press_hits;
    chord_nxt   = (all_released ? 1'b0 : chord_r) | (|chord_hits);
    hold_base   = all_released ? 1'b0 : hold_r;
    latched_nxt = latched_r;
    hold_nxt    = hold_base;
    if (chord_nxt && !hold_base) begin
      latched_nxt = pressed_nxt;
      hold_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_r <= '0;
      latched_r <= '0;
      chord_r   <= 1'b0;
      hold_r    <= 1'b0;
    end else if (step) begin
      pressed_r <= pressed_nxt;
      latched_r <= latched_nxt;
      chord_r   <= chord_nxt;
      hold_r    <= hold_nxt;
    end
  end

  assign pressed_wide = CW'(pressed_r);
  assign latched_wide = CW'(latched_r);

  assign result.pressed_keys = pressed_wide[ckd_pkg::FIELD_W-1:0];
  assign result.chord_seen   = chord_r;
  assign result.hold_active  = hold_r;
  assign result.chord_keys   = latched_wide[ckd_pkg::FIELD_W-1:0];

endmodule
